// File: hw/rtl/crot_pkg.sv
package crot_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int CLICK_BITS  = 24;

  localparam int KEY_W   = 16;
  localparam int OP_W    = 3;
  localparam int STAT_W  = 2;
  localparam int POS_W   = 4;
  localparam int DEC_W   = 8;
  localparam int IDX_W   = $clog2(MAX_ENTRIES);
  localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
  localparam int SUM_W   = CLICK_BITS + IDX_W;
  localparam int TOT_W   = (SUM_W > 16) ? SUM_W : 16;
  localparam int PROD_W  = CLICK_BITS + 8;
  localparam int MRG_W   = 14;
  localparam int NEED_W  = ((CLICK_BITS > MRG_W) ? CLICK_BITS : MRG_W) + 1;

  localparam logic [CLICK_BITS-1:0] CLICK_MAX = {CLICK_BITS{1'b1}};

  localparam int IN_BITS  = OP_W + 2 * KEY_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = STAT_W + 1 + POS_W + CLICK_BITS + 1 + DEC_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [OP_W-1:0] OP_APPEND  = 3'd0;
  localparam logic [OP_W-1:0] OP_CLICK   = 3'd1;
  localparam logic [OP_W-1:0] OP_DISMISS = 3'd2;
  localparam logic [OP_W-1:0] OP_TICK    = 3'd3;
  localparam logic [OP_W-1:0] OP_COMPARE = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_NF   = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_BASE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXTRA   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_TOT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NUM     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEN     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PEN     = 3'd6;

  typedef struct packed {
    logic [KEY_W-1:0]      key;
    logic [CLICK_BITS-1:0] clicks;
  } entry_t;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  addr;
    entry_t            data;
  } mem_wr_t;

  typedef struct packed {
    logic [7:0]  base;
    logic [4:0]  top;
    logic [7:0]  extra;
    logic [15:0] min_tot;
    logic [7:0]  num;
    logic [7:0]  den;
    logic [3:0]  pen;
  } cfg_t;

  typedef struct packed {
    logic [DEC_W-1:0]      decays;
    logic                  moved;
    logic [CLICK_BITS-1:0] clicks;
    logic [POS_W-1:0]      pos;
    logic                  first;
    logic [STAT_W-1:0]     status;
  } res_t;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [7:0]        divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] quot;
  } div_rsp_t;

endpackage

// File: hw/rtl/crot_mem.sv
module crot_mem (
  input  logic                        clk,
  input  crot_pkg::mem_wr_t           wr,
  input  logic [crot_pkg::IDX_W-1:0]  raddr,
  output crot_pkg::entry_t            rdata
);

  crot_pkg::entry_t mem [crot_pkg::MAX_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/crot_div.sv
module crot_div (
  input  logic                clk,
  input  logic                rst_n,
  input  crot_pkg::div_req_t  req,
  output crot_pkg::div_rsp_t  rsp
);

  localparam int CW = $clog2(crot_pkg::PROD_W + 1);

  logic [crot_pkg::PROD_W-1:0] q_r, q_nxt;
  logic [7:0]                  rem_r, rem_nxt;
  logic [7:0]                  dv_r, dv_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [8:0]                  trial;
  logic                        ge;

  always_comb begin
    trial    = {rem_r, q_r[crot_pkg::PROD_W-1]};
    ge       = trial >= {1'b0, dv_r};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dv_nxt   = dv_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      q_nxt    = req.dividend;
      rem_nxt  = '0;
      // zero divisor behaves as one
      dv_nxt   = (req.divisor == 8'd0) ? 8'd1 : req.divisor;
      cnt_nxt  = CW'(crot_pkg::PROD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // one quotient bit a cycle, restoring
      rem_nxt = ge ? 8'(trial - {1'b0, dv_r}) : trial[7:0];
      q_nxt   = {q_r[crot_pkg::PROD_W-2:0], ge};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dv_r  <= dv_nxt;
    cnt_r <= cnt_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;

endmodule

// File: hw/rtl/crot_seq.sv
module crot_seq (
  input  logic                           clk,
  input  logic                           rst_n,
  input  crot_pkg::cfg_t                 cfg,
  input  logic                           start,
  input  logic [crot_pkg::OP_W-1:0]      op,
  input  logic [crot_pkg::KEY_W-1:0]     key,
  input  logic [crot_pkg::KEY_W-1:0]     oth,
  output logic                           idle,
  output logic                           done,
  input  logic                           ack,
  output crot_pkg::res_t                 res,
  output crot_pkg::mem_wr_t              mw,
  output logic [crot_pkg::IDX_W-1:0]     raddr,
  input  crot_pkg::entry_t               rdata,
  output crot_pkg::div_req_t             dreq,
  input  crot_pkg::div_rsp_t             drsp
);

  localparam int IW = crot_pkg::IDX_W;
  localparam int NW = crot_pkg::CNT_W;
  localparam int CB = crot_pkg::CLICK_BITS;
  localparam int DW = NW + 4;
  localparam int XW = IW + 5;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_SRD  = 5'd1;
  localparam logic [4:0] S_SCMP = 5'd2;
  localparam logic [4:0] S_DISP = 5'd3;
  localparam logic [4:0] S_DCHK = 5'd4;
  localparam logic [4:0] S_DRD  = 5'd5;
  localparam logic [4:0] S_DMUL = 5'd6;
  localparam logic [4:0] S_DST  = 5'd7;
  localparam logic [4:0] S_DDIV = 5'd8;
  localparam logic [4:0] S_CRD0 = 5'd9;
  localparam logic [4:0] S_CRD1 = 5'd10;
  localparam logic [4:0] S_CUPD = 5'd11;
  localparam logic [4:0] S_CWR2 = 5'd12;
  localparam logic [4:0] S_MRD  = 5'd13;
  localparam logic [4:0] S_MWR  = 5'd14;
  localparam logic [4:0] S_MNX  = 5'd15;
  localparam logic [4:0] S_MFIN = 5'd16;
  localparam logic [4:0] S_DONE = 5'd17;

  logic [4:0]                    st_r, st_nxt;
  logic [crot_pkg::OP_W-1:0]     op_r, op_nxt;
  logic [crot_pkg::KEY_W-1:0]    key_r, key_nxt, oth_r, oth_nxt;
  logic [NW-1:0]                 idx_r, idx_nxt;
  logic                          sf_r, sf_nxt, rf_r, rf_nxt;
  logic [IW-1:0]                 si_r, si_nxt, ri_r, ri_nxt;
  logic [CB-1:0]                 sc_r, sc_nxt;
  logic [crot_pkg::TOT_W-1:0]    tot_r, tot_nxt, acc_r, acc_nxt;
  logic [7:0]                    dn_r, dn_nxt;
  logic [NW-1:0]                 used_r, used_nxt;
  logic [7:0]                    pend_r, pend_nxt;
  logic                          tmr_r, tmr_nxt;
  logic [crot_pkg::PROD_W-1:0]   prod_r, prod_nxt;
  crot_pkg::entry_t              ent_r, ent_nxt, prev_r, prev_nxt;
  logic [IW-1:0]                 tgt_r, tgt_nxt;
  logic [CB-1:0]                 nclk_r, nclk_nxt;
  crot_pkg::res_t                res_r, res_nxt;

  logic [CB-1:0]                 sat;
  logic [CB-1:0]                 cinc;
  logic [XW-1:0]                 pidx_x, top_x;
  logic [crot_pkg::MRG_W-1:0]    margin;
  logic [crot_pkg::NEED_W-1:0]   need;
  logic [DW-1:0]                 room, pen_x, kstep;
  logic [CB-1:0]                 base_c, dclk;

  always_comb begin
    sat = (drsp.quot > crot_pkg::PROD_W'(crot_pkg::CLICK_MAX)) ? crot_pkg::CLICK_MAX
                                                             : drsp.quot[CB-1:0];
    cinc = (rdata.clicks == crot_pkg::CLICK_MAX) ? rdata.clicks : rdata.clicks + CB'(1);
    // passing margin of the predecessor slot
    pidx_x = XW'(si_r - IW'(1));
    top_x  = XW'(cfg.top);
    margin = crot_pkg::MRG_W'(cfg.base);
    if (pidx_x < top_x) begin
      margin = margin + crot_pkg::MRG_W'(cfg.extra * 5'(top_x - pidx_x));
    end
    need  = crot_pkg::NEED_W'(rdata.clicks) + crot_pkg::NEED_W'(margin);
    room  = DW'(used_r - NW'(1)) - DW'(si_r);
    pen_x = DW'(cfg.pen);
    kstep = (pen_x < room) ? pen_x : room;
    base_c = CB'(cfg.base);
    dclk   = (nclk_r > base_c) ? nclk_r - base_c : '0;
  end

  always_comb begin
    st_nxt   = st_r;
    op_nxt   = op_r;
    key_nxt  = key_r;
    oth_nxt  = oth_r;
    idx_nxt  = idx_r;
    sf_nxt   = sf_r;
    rf_nxt   = rf_r;
    si_nxt   = si_r;
    ri_nxt   = ri_r;
    sc_nxt   = sc_r;
    tot_nxt  = tot_r;
    acc_nxt  = acc_r;
    dn_nxt   = dn_r;
    used_nxt = used_r;
    pend_nxt = pend_r;
    tmr_nxt  = tmr_r;
    prod_nxt = prod_r;
    ent_nxt  = ent_r;
    prev_nxt = prev_r;
    tgt_nxt  = tgt_r;
    nclk_nxt = nclk_r;
    res_nxt  = res_r;
    mw       = '0;
    raddr    = idx_r[IW-1:0];
    dreq          = '0;
    dreq.dividend = prod_r;
    dreq.divisor  = cfg.den;

    unique case (st_r)
      S_IDLE: begin
        if (start) begin
          op_nxt  = op;
          key_nxt = key;
          oth_nxt = oth;
          idx_nxt = '0;
          sf_nxt  = 1'b0;
          rf_nxt  = 1'b0;
          tot_nxt = '0;
          res_nxt = '0;
          st_nxt  = S_SRD;
        end
      end
      S_SRD: begin
        raddr  = idx_r[IW-1:0];
        st_nxt = (idx_r < used_r) ? S_SCMP : S_DISP;
      end
      S_SCMP: begin
        if (!sf_r && rdata.key == key_r) begin
          sf_nxt = 1'b1;
          si_nxt = idx_r[IW-1:0];
          sc_nxt = rdata.clicks;
        end
        if (!rf_r && rdata.key == oth_r) begin
          rf_nxt = 1'b1;
          ri_nxt = idx_r[IW-1:0];
        end
        tot_nxt = tot_r + crot_pkg::TOT_W'(rdata.clicks);
        idx_nxt = idx_r + NW'(1);
        st_nxt  = S_SRD;
      end
      S_DISP: begin
        st_nxt = S_DONE;
        unique case (op_r)
          crot_pkg::OP_APPEND: begin
            if (sf_r) begin
              res_nxt.pos    = crot_pkg::POS_W'(si_r);
              res_nxt.clicks = sc_r;
            end else if (used_r < NW'(crot_pkg::MAX_ENTRIES)) begin
              mw.we          = 1'b1;
              mw.addr        = used_r[IW-1:0];
              mw.data.key    = key_r;
              mw.data.clicks = '0;
              used_nxt       = used_r + NW'(1);
              res_nxt.pos    = crot_pkg::POS_W'(used_r[IW-1:0]);
            end else begin
              res_nxt.status = crot_pkg::ST_FULL;
            end
          end
          crot_pkg::OP_CLICK: begin
            if (!sf_r) begin
              res_nxt.status = crot_pkg::ST_NF;
            end else if (!tmr_r) begin
              tmr_nxt  = 1'b1;
              pend_nxt = '0;
              dn_nxt   = '0;
              st_nxt   = S_CRD0;
            end else begin
              dn_nxt = '0;
              st_nxt = S_DCHK;
            end
          end
          crot_pkg::OP_DISMISS: begin
            if (!sf_r) begin
              res_nxt.status = crot_pkg::ST_NF;
            end else begin
              tgt_nxt = IW'(DW'(si_r) + kstep);
              idx_nxt = NW'(si_r) + NW'(1);
              ent_nxt = '0;
              st_nxt  = S_MRD;
            end
          end
          crot_pkg::OP_TICK: begin
            if (pend_r != 8'hff) begin
              pend_nxt = pend_r + 8'd1;
            end
          end
          crot_pkg::OP_COMPARE: begin
            if (!sf_r || !rf_r) begin
              res_nxt.status = crot_pkg::ST_NF;
            end
            if (key_r == oth_r) begin
              res_nxt.first = 1'b0;
            end else if (sf_r && (!rf_r || si_r < ri_r)) begin
              res_nxt.first = 1'b1;
            end else if (rf_r) begin
              res_nxt.first = 1'b0;
            end else begin
              res_nxt.first = key_r < oth_r;
            end
            if (sf_r) begin
              res_nxt.pos    = crot_pkg::POS_W'(si_r);
              res_nxt.clicks = sc_r;
            end
          end
          default: begin
          end
        endcase
      end
      // decay passes, each over every used slot
      S_DCHK: begin
        if (dn_r < pend_r && tot_r >= crot_pkg::TOT_W'(cfg.min_tot)) begin
          idx_nxt = '0;
          acc_nxt = '0;
          st_nxt  = S_DRD;
        end else begin
          pend_nxt = '0;
          st_nxt   = S_CRD0;
        end
      end
      S_DRD: begin
        raddr  = idx_r[IW-1:0];
        st_nxt = S_DMUL;
      end
      S_DMUL: begin
        ent_nxt  = rdata;
        prod_nxt = crot_pkg::PROD_W'(rdata.clicks * cfg.num);
        st_nxt   = S_DST;
      end
      S_DST: begin
        dreq.start = 1'b1;
        st_nxt     = S_DDIV;
      end
      S_DDIV: begin
        if (drsp.done) begin
          mw.we          = 1'b1;
          mw.addr        = idx_r[IW-1:0];
          mw.data.key    = ent_r.key;
          mw.data.clicks = sat;
          acc_nxt        = acc_r + crot_pkg::TOT_W'(sat);
          if (idx_r + NW'(1) < used_r) begin
            idx_nxt = idx_r + NW'(1);
            st_nxt  = S_DRD;
          end else begin
            tot_nxt = acc_r + crot_pkg::TOT_W'(sat);
            dn_nxt  = dn_r + 8'd1;
            st_nxt  = S_DCHK;
          end
        end
      end
      S_CRD0: begin
        raddr  = si_r;
        st_nxt = S_CRD1;
      end
      S_CRD1: begin
        ent_nxt.key       = rdata.key;
        ent_nxt.clicks    = cinc;
        res_nxt.decays    = dn_r;
        if (si_r == '0) begin
          mw.we          = 1'b1;
          mw.addr        = si_r;
          mw.data.key    = rdata.key;
          mw.data.clicks = cinc;
          res_nxt.pos    = '0;
          res_nxt.clicks = cinc;
          st_nxt         = S_DONE;
        end else begin
          raddr  = si_r - IW'(1);
          st_nxt = S_CUPD;
        end
      end
      S_CUPD: begin
        res_nxt.clicks = ent_r.clicks;
        mw.we          = 1'b1;
        mw.data        = ent_r;
        if (crot_pkg::NEED_W'(ent_r.clicks) >= need) begin
          mw.addr       = si_r - IW'(1);
          prev_nxt      = rdata;
          res_nxt.pos   = crot_pkg::POS_W'(si_r - IW'(1));
          res_nxt.moved = 1'b1;
          st_nxt        = S_CWR2;
        end else begin
          mw.addr     = si_r;
          res_nxt.pos = crot_pkg::POS_W'(si_r);
          st_nxt      = S_DONE;
        end
      end
      S_CWR2: begin
        mw.we   = 1'b1;
        mw.addr = si_r;
        mw.data = prev_r;
        st_nxt  = S_DONE;
      end
      // dismiss: slide followers up, then drop the entry in at its new place
      S_MRD: begin
        raddr = idx_r[IW-1:0];
        if (idx_r <= NW'(tgt_r)) begin
          st_nxt = S_MWR;
        end else if (idx_r < used_r) begin
          st_nxt = S_MNX;
        end else begin
          nclk_nxt = '0;
          st_nxt   = S_MFIN;
        end
      end
      S_MWR: begin
        mw.we   = 1'b1;
        mw.addr = IW'(idx_r - NW'(1));
        mw.data = rdata;
        idx_nxt = idx_r + NW'(1);
        st_nxt  = S_MRD;
      end
      S_MNX: begin
        nclk_nxt = rdata.clicks;
        st_nxt   = S_MFIN;
      end
      S_MFIN: begin
        mw.we          = 1'b1;
        mw.addr        = tgt_r;
        mw.data.key    = key_r;
        mw.data.clicks = dclk;
        res_nxt.pos    = crot_pkg::POS_W'(tgt_r);
        res_nxt.clicks = dclk;
        res_nxt.moved  = tgt_r != si_r;
        st_nxt         = S_DONE;
      end
      S_DONE: begin
        if (ack) begin
          st_nxt = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      used_r <= '0;
      pend_r <= '0;
      tmr_r  <= 1'b1;
    end else begin
      st_r   <= st_nxt;
      used_r <= used_nxt;
      pend_r <= pend_nxt;
      tmr_r  <= tmr_nxt;
    end
    op_r   <= op_nxt;
    key_r  <= key_nxt;
    oth_r  <= oth_nxt;
    idx_r  <= idx_nxt;
    sf_r   <= sf_nxt;
    rf_r   <= rf_nxt;
    si_r   <= si_nxt;
    ri_r   <= ri_nxt;
    sc_r   <= sc_nxt;
    tot_r  <= tot_nxt;
    acc_r  <= acc_nxt;
    dn_r   <= dn_nxt;
    prod_r <= prod_nxt;
    ent_r  <= ent_nxt;
    prev_r <= prev_nxt;
    tgt_r  <= tgt_nxt;
    nclk_r <= nclk_nxt;
    res_r  <= res_nxt;
  end

  assign idle = st_r == S_IDLE;
  assign done = st_r == S_DONE;
  assign res  = res_r;

endmodule

// File: hw/rtl/click_ranked_order_table.sv
// Ordered table of up to 16 ids with saturating click counts, held in one
// single-port-read memory and worked on by a sequencer, one request at a time.
// Every request first scans the used slots; append, tick and compare then
// finish directly, dismiss moves the entry past its followers, and a click
// updates the entry and may swap it with its predecessor. Each decay pass a
// click runs sends every used slot through the divider, which makes one
// quotient bit a cycle. No clearing pass is needed after reset. A finished
// result waits in the output register while the next request is taken.
module click_ranked_order_table (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // operation, entry_key, other_key
  input  logic [crot_pkg::IN_W-1:0]           in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // status, ranks_first, position, click_count, moved, decays_done
  output logic [crot_pkg::OUT_W-1:0]          out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [crot_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [crot_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int KW = crot_pkg::KEY_W;
  localparam int OW = crot_pkg::OP_W;

  crot_pkg::cfg_t     cfg_r, cfg_nxt;
  logic               ov_r, ov_nxt;
  crot_pkg::res_t     od_r, od_nxt;
  logic               idle, done, free;
  crot_pkg::res_t     res;
  crot_pkg::mem_wr_t  mw;
  logic [crot_pkg::IDX_W-1:0] raddr;
  crot_pkg::entry_t   rdata;
  crot_pkg::div_req_t dreq;
  crot_pkg::div_rsp_t drsp;

  assign cfg_ready = 1'b1;
  assign in_tready = idle;
  assign free      = !ov_r || out_tready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        crot_pkg::REG_BASE:    cfg_nxt.base    = cfg_data[7:0];
        crot_pkg::REG_TOP:     cfg_nxt.top     = cfg_data[4:0];
        crot_pkg::REG_EXTRA:   cfg_nxt.extra   = cfg_data[7:0];
        crot_pkg::REG_MIN_TOT: cfg_nxt.min_tot = cfg_data;
        crot_pkg::REG_NUM:     cfg_nxt.num     = cfg_data[7:0];
        crot_pkg::REG_DEN:     cfg_nxt.den     = cfg_data[7:0];
        crot_pkg::REG_PEN:     cfg_nxt.pen     = cfg_data[3:0];
        default: begin
        end
      endcase
    end
    ov_nxt = ov_r;
    od_nxt = od_r;
    if (done && free) begin
      ov_nxt = 1'b1;
      od_nxt = res;
    end else if (out_tready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base    <= 8'd5;
      cfg_r.top     <= 5'd3;
      cfg_r.extra   <= 8'd2;
      cfg_r.min_tot <= 16'd30;
      cfg_r.num     <= 8'd91;
      cfg_r.den     <= 8'd100;
      cfg_r.pen     <= 4'd1;
      ov_r          <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
      ov_r  <= ov_nxt;
    end
    od_r <= od_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = crot_pkg::OUT_W'(od_r);

  crot_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .start (in_tvalid && idle),
    .op    (in_tdata[OW-1:0]),
    .key   (in_tdata[OW+KW-1:OW]),
    .oth   (in_tdata[OW+2*KW-1:OW+KW]),
    .idle  (idle),
    .done  (done),
    .ack   (free),
    .res   (res),
    .mw    (mw),
    .raddr (raddr),
    .rdata (rdata),
    .dreq  (dreq),
    .drsp  (drsp)
  );

  crot_mem u_mem (
    .clk   (clk),
    .wr    (mw),
    .raddr (raddr),
    .rdata (rdata)
  );

  crot_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

endmodule

// File: tb/sv/click_ranked_order_table_chk.sv
module click_ranked_order_table_chk (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [crot_pkg::IN_W-1:0]       in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [crot_pkg::OUT_W-1:0]      out_tdata,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [crot_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [crot_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              pending_results
);

  localparam int KW = crot_pkg::KEY_W;
  localparam int CB = crot_pkg::CLICK_BITS;
  localparam int OW = crot_pkg::OP_W;

  logic [KW-1:0]         tbl_key [crot_pkg::MAX_ENTRIES];
  logic [CB-1:0]         tbl_clk [crot_pkg::MAX_ENTRIES];
  int unsigned           n_used;
  int unsigned           n_pending;
  bit                    timer_on;
  crot_pkg::cfg_t        cfg;
  crot_pkg::res_t        res_q[$];

  assign pending_results = res_q.size();

  function automatic int locate(logic [KW-1:0] k);
    for (int i = 0; i < n_used; i++)
      if (tbl_key[i] == k) return i;
    return -1;
  endfunction

  function automatic void swap_pos(int a, int b);
    logic [KW-1:0] k;
    logic [CB-1:0] c;
    k = tbl_key[a]; c = tbl_clk[a];
    tbl_key[a] = tbl_key[b]; tbl_clk[a] = tbl_clk[b];
    tbl_key[b] = k; tbl_clk[b] = c;
  endfunction

  function automatic longint unsigned margin_at(int p);
    longint unsigned m;
    m = cfg.base;
    if (p < cfg.top) m += longint'(cfg.extra) * (cfg.top - p);
    return m;
  endfunction

  function automatic int unsigned apply_decays();
    int unsigned     done;
    longint unsigned den, sum, v;
    done = 0;
    den = (cfg.den == 0) ? 1 : cfg.den;
    if (!timer_on) begin
      timer_on = 1'b1;
      n_pending = 0;
      return 0;
    end
    while (done < n_pending) begin
      sum = 0;
      for (int i = 0; i < n_used; i++) sum += tbl_clk[i];
      if (sum < cfg.min_tot) break;
      for (int i = 0; i < n_used; i++) begin
        v = longint'(tbl_clk[i]) * cfg.num / den;
        tbl_clk[i] = (v > crot_pkg::CLICK_MAX) ? crot_pkg::CLICK_MAX : v[CB-1:0];
      end
      done++;
    end
    n_pending = 0;
    return done;
  endfunction

  function automatic crot_pkg::res_t rank_request(logic [OW-1:0] op, logic [KW-1:0] k,
                                                  logic [KW-1:0] o);
    crot_pkg::res_t  r;
    int              s, q, p;
    longint unsigned nxt;
    r = '0;
    s = locate(k);
    case (op)
      crot_pkg::OP_APPEND: begin
        if (s < 0) begin
          if (n_used < crot_pkg::MAX_ENTRIES) begin
            s = n_used;
            tbl_key[s] = k;
            tbl_clk[s] = '0;
            n_used++;
          end else r.status = crot_pkg::ST_FULL;
        end
        if (s >= 0) begin
          r.pos = crot_pkg::POS_W'(s);
          r.clicks = tbl_clk[s];
        end
      end
      crot_pkg::OP_CLICK: begin
        if (s < 0) r.status = crot_pkg::ST_NF;
        else begin
          p = s;
          r.decays = crot_pkg::DEC_W'(apply_decays());
          if (tbl_clk[p] < crot_pkg::CLICK_MAX) tbl_clk[p]++;
          if (p > 0 && longint'(tbl_clk[p]) >= longint'(tbl_clk[p-1]) + margin_at(p-1)) begin
            swap_pos(p, p - 1);
            p--;
            r.moved = 1'b1;
          end
          r.pos = crot_pkg::POS_W'(p);
          r.clicks = tbl_clk[p];
        end
      end
      crot_pkg::OP_DISMISS: begin
        if (s < 0) r.status = crot_pkg::ST_NF;
        else begin
          p = s;
          for (int d = 0; d < cfg.pen && p + 1 < n_used; d++) begin
            swap_pos(p, p + 1);
            p++;
            r.moved = 1'b1;
          end
          nxt = (p + 1 < n_used) ? tbl_clk[p+1] : 0;
          tbl_clk[p] = CB'((nxt > cfg.base) ? nxt - cfg.base : 0);
          r.pos = crot_pkg::POS_W'(p);
          r.clicks = tbl_clk[p];
        end
      end
      crot_pkg::OP_TICK: if (n_pending < 255) n_pending++;
      crot_pkg::OP_COMPARE: begin
        q = locate(o);
        if (s < 0 || q < 0) r.status = crot_pkg::ST_NF;
        if (k == o) r.first = 1'b0;
        else if (s >= 0 && (q < 0 || s < q)) r.first = 1'b1;
        else if (q >= 0) r.first = 1'b0;
        else r.first = (k < o);
        if (s >= 0) begin
          r.pos = crot_pkg::POS_W'(s);
          r.clicks = tbl_clk[s];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    crot_pkg::res_t want, got, pred;
    if (!rst_n) begin
      n_used = 0;
      n_pending = 0;
      timer_on = 1'b1;
      cfg = '{base: 8'd5, top: 5'd3, extra: 8'd2, min_tot: 16'd30, num: 8'd91,
              den: 8'd100, pen: 4'd1};
      res_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          crot_pkg::REG_BASE:    cfg.base    = cfg_data[7:0];
          crot_pkg::REG_TOP:     cfg.top     = cfg_data[4:0];
          crot_pkg::REG_EXTRA:   cfg.extra   = cfg_data[7:0];
          crot_pkg::REG_MIN_TOT: cfg.min_tot = cfg_data[15:0];
          crot_pkg::REG_NUM:     cfg.num     = cfg_data[7:0];
          crot_pkg::REG_DEN:     cfg.den     = cfg_data[7:0];
          crot_pkg::REG_PEN:     cfg.pen     = cfg_data[3:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[crot_pkg::OUT_BITS-1:0];
        if (res_q.size() == 0) begin
          $error("unexpected result %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = res_q.pop_front();
          if (got != want) begin
            fail_count <= fail_count + 1;
            if (got.status != want.status)
              $error("status exp %0d got %0d", want.status, got.status);
            if (got.first != want.first)
              $error("ranks_first exp %0d got %0d", want.first, got.first);
            if (got.pos != want.pos)
              $error("position exp %0d got %0d", want.pos, got.pos);
            if (got.clicks != want.clicks)
              $error("click_count exp %0d got %0d", want.clicks, got.clicks);
            if (got.moved != want.moved)
              $error("moved exp %0d got %0d", want.moved, got.moved);
            if (got.decays != want.decays)
              $error("decays_done exp %0d got %0d", want.decays, got.decays);
          end
        end
      end
      // request taken after any result of the same edge is popped
      if (in_tvalid && in_tready) begin
        pred = rank_request(in_tdata[OW-1:0], in_tdata[OW+:KW], in_tdata[OW+KW+:KW]);
        res_q = {res_q, pred};
      end
    end
  end

endmodule

// File: tb/sv/click_ranked_order_table_tb.sv
module click_ranked_order_table_tb;

  localparam int KW = crot_pkg::KEY_W;
  localparam int OW = crot_pkg::OP_W;
  localparam int DW = crot_pkg::CFG_DATA_W;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [crot_pkg::IN_W-1:0]       in_tdata;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [crot_pkg::OUT_W-1:0]      out_tdata;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [crot_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [DW-1:0]                   cfg_data;
  int                              fail_count;
  int                              pending_results;
  int unsigned                     cycle_no = 0;
  int unsigned                     stall_left;
  bit                              calm;
  logic [KW-1:0]                   key_pool [24];

  click_ranked_order_table dut (.*);
  click_ranked_order_table_chk chk (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // about 1300 requests; a click after saturated ticks runs up to 255 decay passes
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (cycle_no > 3000000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side stalls in random bursts unless calm
  always @(posedge clk) begin
    if (!rst_n || calm) begin
      stall_left <= 0;
      out_tready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left <= $urandom_range(0, 5);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic send_req(logic [OW-1:0] op, logic [KW-1:0] k, logic [KW-1:0] o);
    logic [crot_pkg::IN_W-1:0] d;
    d = '0;
    d[OW-1:0] = op;
    d[OW+:KW] = k;
    d[OW+KW+:KW] = o;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_reg(logic [crot_pkg::CFG_IDX_W-1:0] idx, logic [DW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_results != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic set_regs(int b, int t, int e, int m, int n, int d, int p);
    drain();
    write_reg(crot_pkg::REG_BASE, DW'(b));
    write_reg(crot_pkg::REG_TOP, DW'(t));
    write_reg(crot_pkg::REG_EXTRA, DW'(e));
    write_reg(crot_pkg::REG_MIN_TOT, DW'(m));
    write_reg(crot_pkg::REG_NUM, DW'(n));
    write_reg(crot_pkg::REG_DEN, DW'(d));
    write_reg(crot_pkg::REG_PEN, DW'(p));
    cfg_valid <= 1'b0;
  endtask

  task automatic key_ops(int count);
    logic [KW-1:0] k, o;
    int            r;
    for (int i = 0; i < count; i++) begin
      k = key_pool[$urandom_range(0, 23)];
      o = key_pool[$urandom_range(0, 23)];
      if ($urandom_range(0, 15) == 0) k = KW'($urandom);
      if ($urandom_range(0, 15) == 0) o = KW'($urandom);
      r = $urandom_range(0, 99);
      if (r < 12)      send_req(crot_pkg::OP_APPEND, k, KW'($urandom));
      else if (r < 60) send_req(crot_pkg::OP_CLICK, k, KW'($urandom));
      else if (r < 72) send_req(crot_pkg::OP_DISMISS, k, KW'($urandom));
      else if (r < 82) send_req(crot_pkg::OP_TICK, k, KW'($urandom));
      else if (r < 96) send_req(crot_pkg::OP_COMPARE, k, o);
      else send_req(OW'($urandom_range(int'(crot_pkg::OP_COMPARE) + 1, (1 << OW) - 1)), k, o);
    end
  endtask

  initial begin
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    cfg_valid = 0;
    cfg_index = '0;
    cfg_data = '0;
    calm = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: missing ids, fill past capacity, ops at extremes
    send_req(crot_pkg::OP_CLICK, 16'hffff, '0);
    send_req(crot_pkg::OP_DISMISS, 16'h0000, '0);
    send_req(crot_pkg::OP_COMPARE, 16'h0001, 16'h0002);
    send_req(crot_pkg::OP_COMPARE, 16'h0005, 16'h0005);
    for (int i = 0; i < 17; i++)
      send_req(crot_pkg::OP_APPEND, (i == 16) ? 16'hffff : KW'(i * 4099), '0);
    send_req(crot_pkg::OP_APPEND, 16'h0000, '0);
    send_req(crot_pkg::OP_DISMISS, KW'(15 * 4099), '0);
    send_req(crot_pkg::OP_TICK, '0, '0);
    send_req(crot_pkg::OP_CLICK, 16'd4099, '0);
    send_req({OW{1'b1}}, 16'hffff, 16'hffff);

    // the table stays full of the directed ids, a few absent ids beside them
    for (int i = 0; i < 24; i++) key_pool[i] = (i < 16) ? KW'(i * 4099) : KW'($urandom);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: ;
        1: set_regs(0, 0, 0, 0, 255, 0, 15);     // zero denominator, growth
        2: set_regs(255, 16, 255, 65535, 0, 255, 0);
        3: set_regs(1, 2, 1, 5, 50, 100, 2);
        4: set_regs(2, 4, 1, 0, 200, 1, 3);       // decays saturate
        5: set_regs(3, 1, 3, 20, 1, 2, 1);
        6: set_regs(0, 16, 0, 10, 91, 100, 15);
        default: set_regs(5, 3, 2, 30, 91, 100, 1);
      endcase
      drain();
      for (int i = 0; i < 20; i++) send_req(crot_pkg::OP_APPEND, key_pool[i], KW'($urandom));
      if (ph == 7) calm = 1;
      key_ops(100);
      // pending decays saturate once
      for (int i = 0; i < ((ph == 1) ? 260 : 6); i++)
        send_req(crot_pkg::OP_TICK, KW'($urandom), KW'($urandom));
      send_req(crot_pkg::OP_CLICK, key_pool[0], '0);
    end

    drain();
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
